>>> rtl/pm_sensor_frame_parser_defines.svh
// Assertion macros shared by the sensor frame parser RTL.
// Each macro expects clk and rst_n to be in scope at the point of use.
`ifndef PM_SENSOR_FRAME_PARSER_DEFINES_SVH
`define PM_SENSOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PMSFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PMSFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pmsfp_pkg.sv
// Types and constants for the sensor frame parser.
// No dependencies; imported by every module of the block except pmsfp_in_reg.
`timescale 1ns / 1ps

package pmsfp_pkg;

  // Frame position codes (next byte expected)
  localparam logic [3:0] POS_HUNT    = 4'd0;
  localparam logic [3:0] POS_TYPE    = 4'd1;
  localparam logic [3:0] POS_PM25_LO = 4'd2;
  localparam logic [3:0] POS_ID_HI   = 4'd7;
  localparam logic [3:0] POS_TAIL    = 4'd9;

  // Capture slots
  localparam int unsigned CAP_DEPTH = 8;
  localparam int unsigned CAP_IDX_W = 3;
  localparam logic [CAP_IDX_W-1:0] CAP_TYPE    = 3'd0;
  localparam logic [CAP_IDX_W-1:0] CAP_PM25_LO = 3'd1;
  localparam logic [CAP_IDX_W-1:0] CAP_PM25_HI = 3'd2;
  localparam logic [CAP_IDX_W-1:0] CAP_PM10_LO = 3'd3;
  localparam logic [CAP_IDX_W-1:0] CAP_PM10_HI = 3'd4;
  localparam logic [CAP_IDX_W-1:0] CAP_ID_LO   = 3'd5;
  localparam logic [CAP_IDX_W-1:0] CAP_ID_HI   = 3'd6;
  localparam logic [CAP_IDX_W-1:0] CAP_CHECK   = 3'd7;

  // Frame status codes
  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;

  // Config register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 2'd1;

  localparam logic [7:0] HEAD_RST = 8'hAA;
  localparam logic [7:0] TAIL_RST = 8'hAB;

  typedef struct packed {
    logic [15:0] pm25_tenths;
    logic [15:0] pm10_tenths;
    logic [15:0] sensor_id;
    logic [7:0]  frame_type;
    logic [1:0]  frame_status;
  } pmsfp_result_t;

endpackage

>>> rtl/pmsfp_in_reg.sv
// Input register for received bytes.
// No package dependencies.
`timescale 1ns / 1ps

module pmsfp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       accept;

  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

>>> rtl/pmsfp_framer.sv
// Frame tracker: position, running checksum, byte capture and frame judgment.
// Depends on pmsfp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "pm_sensor_frame_parser_defines.svh"

module pmsfp_framer
  import pmsfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    byte_data,
  input  logic [7:0]    head_byte,
  input  logic [7:0]    tail_byte,
  output logic          res_valid,
  output pmsfp_result_t res
);

  logic [3:0]           pos_r, pos_nxt;
  logic [7:0]           sum_r, sum_nxt;
  logic [7:0]           cap_r [CAP_DEPTH];
  logic                 cap_we;
  logic [3:0]           pos_m1;
  logic [CAP_IDX_W-1:0] cap_idx;
  logic                 hunting;
  logic                 head_hit;

  assign hunting  = (pos_r == POS_HUNT) || (pos_r > POS_TAIL);
  assign head_hit = (byte_data == head_byte);
  assign pos_m1   = pos_r - 4'd1;
  assign cap_idx  = pos_m1[CAP_IDX_W-1:0];

  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    cap_we    = 1'b0;
    res_valid = 1'b0;
    if (step) begin
      if (hunting) begin
        pos_nxt = head_hit ? POS_TYPE : POS_HUNT;
        sum_nxt = '0;
      end else if (pos_r == POS_TAIL) begin
        pos_nxt   = POS_HUNT;
        sum_nxt   = '0;
        res_valid = 1'b1;
      end else begin
        cap_we  = 1'b1;
        // only the six data bytes feed the checksum
        if (pos_r >= POS_PM25_LO && pos_r <= POS_ID_HI) begin
          sum_nxt = sum_r + byte_data;
        end
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_comb begin
    res.pm25_tenths = {cap_r[CAP_PM25_HI], cap_r[CAP_PM25_LO]};
    res.pm10_tenths = {cap_r[CAP_PM10_HI], cap_r[CAP_PM10_LO]};
    res.sensor_id   = {cap_r[CAP_ID_HI], cap_r[CAP_ID_LO]};
    res.frame_type  = cap_r[CAP_TYPE];
    // checksum error wins over tail error
    priority if (cap_r[CAP_CHECK] != sum_r) begin
      res.frame_status = ST_CSUM;
    end else if (byte_data != tail_byte) begin
      res.frame_status = ST_TAIL;
    end else begin
      res.frame_status = ST_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_r[cap_idx] <= byte_data;
    end
  end

  `PMSFP_ASSERT_NOW(a_sum_hunt, pos_r == POS_HUNT, sum_r == 8'd0, "sum not clear while hunting")
  `PMSFP_ASSERT_NEXT(a_tail_hunt, step && pos_r == POS_TAIL, pos_r == POS_HUNT, "stuck after tail")
  `PMSFP_ASSERT_NEXT(a_hunt_hold, pos_r == POS_HUNT && !head_hit, pos_r == POS_HUNT, "hunt exit")

endmodule

>>> rtl/pmsfp_out_reg.sv
// Result register: holds one parsed frame until the downstream side takes it.
// Depends on pmsfp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "pm_sensor_frame_parser_defines.svh"

module pmsfp_out_reg
  import pmsfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  pmsfp_result_t load_data,
  output logic          can_load,
  output logic          out_valid,
  input  logic          out_stall,
  output pmsfp_result_t out_data
);

  logic          valid_r, valid_nxt;
  pmsfp_result_t data_r;

  // free when empty or when the held beat leaves this cycle
  assign can_load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  `PMSFP_ASSERT_NOW(a_no_overwrite, load, !(valid_r && out_stall), "result overwritten while stalled")

endmodule

>>> rtl/pm_sensor_frame_parser.sv
// Top level of the particulate-sensor serial frame parser.
// Depends on pmsfp_pkg, pmsfp_in_reg, pmsfp_framer and pmsfp_out_reg.
`timescale 1ns / 1ps

// Takes one received byte per beat and parses 10-byte sensor frames (head, type,
// PM2.5 lo/hi, PM10 lo/hi, ID lo/hi, checksum, tail). Bytes are dropped until the
// head byte; a result is produced on every tail byte, with frame_status 0 good,
// 1 checksum mismatch, 2 tail mismatch. A bad frame is not rescanned. One byte is
// accepted every cycle while the result register is free; the result of a tail
// byte goes through the input register and then the result register, and waits
// in the input register while the result register is not free. The pipeline
// advances only when the result register is free, so a held out_stall backs up
// into in_stall.
// Head and tail values are set through the cfg port (index 0 head, 1 tail;
// other indexes ignored) and take effect from the next byte.

module pm_sensor_frame_parser
  import pmsfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_pm25_tenths,
  output logic [15:0]          out_pm10_tenths,
  output logic [15:0]          out_sensor_id,
  output logic [7:0]           out_frame_type,
  output logic [1:0]           out_frame_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  logic [7:0]    head_r, tail_r;
  logic          advance;
  logic          byte_valid;
  logic [7:0]    byte_data;
  logic          step;
  logic          res_valid;
  pmsfp_result_t res;
  pmsfp_result_t out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= HEAD_RST;
      tail_r <= TAIL_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_HEAD) begin
        head_r <= cfg_wdata;
      end
      if (cfg_index == CFG_TAIL) begin
        tail_r <= cfg_wdata;
      end
    end
  end

  assign step = byte_valid && advance;

  pmsfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  pmsfp_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_data (byte_data),
    .head_byte (head_r),
    .tail_byte (tail_r),
    .res_valid (res_valid),
    .res       (res)
  );

  pmsfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .can_load  (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_pm25_tenths  = out_data.pm25_tenths;
  assign out_pm10_tenths  = out_data.pm10_tenths;
  assign out_sensor_id    = out_data.sensor_id;
  assign out_frame_type   = out_data.frame_type;
  assign out_frame_status = out_data.frame_status;

endmodule
